@@ sv/assert_macros.svh @@
// Assertion macros shared by the converter RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/yuv420_pkg.sv @@
// Shared types and constants for the YUYV to planar 4:2:0 converter.
// No dependencies.
package yuv420_pkg;

   // Field and register widths
   localparam int BYTE_W     = 8;
   localparam int SIZE_W     = 13;
   localparam int LUMA_PTR_W = 24;
   localparam int CHROMA_PTR_W = 23;
   localparam int PLANE_W    = 25;
   localparam int AREA_W     = 2 * SIZE_W;
   localparam int CSR_IDX_W  = 2;

   // Defaults
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int RESET_WIDTH    = 640;
   localparam int RESET_HEIGHT   = 480;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1
   } csr_index_type;

   // Frame geometry handed to the datapath
   typedef struct packed {
      logic [SIZE_W-1:0]  eff_width;
      logic [SIZE_W-1:0]  eff_height;
      logic [PLANE_W-1:0] u_base;
      logic [PLANE_W-1:0] v_base;
      logic               busy;
   } geom_type;

endpackage

@@ sv/yuv420_geom.sv @@
// Frame size registers, clamping and plane base computation.
// Depends on yuv420_pkg and assert_macros.svh.
`include "assert_macros.svh"

module yuv420_geom #(
   parameter int MAX_WIDTH  = yuv420_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = yuv420_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [yuv420_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [yuv420_pkg::SIZE_W-1:0]       csr_wdata,
   output yuv420_pkg::geom_type                geom
);
   import yuv420_pkg::*;

   localparam int MaxWEven = MAX_WIDTH - (MAX_WIDTH % 2);

   // Even width clamped to [2, MAX_WIDTH]
   function automatic logic [SIZE_W-1:0] clamp_w(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] w;
      w = {raw[SIZE_W-1:1], 1'b0};
      if (w < SIZE_W'(2)) begin
         w = SIZE_W'(2);
      end else if ({1'b0, w} > (SIZE_W+1)'(MAX_WIDTH)) begin
         w = SIZE_W'(MaxWEven);
      end
      return w;
   endfunction

   // Height clamped to [1, MAX_HEIGHT]
   function automatic logic [SIZE_W-1:0] clamp_h(input logic [SIZE_W-1:0] raw);
      logic [SIZE_W-1:0] h;
      h = raw;
      if (h < SIZE_W'(1)) begin
         h = SIZE_W'(1);
      end else if ({1'b0, h} > (SIZE_W+1)'(MAX_HEIGHT)) begin
         h = SIZE_W'(MAX_HEIGHT);
      end
      return h;
   endfunction

   localparam logic [SIZE_W-1:0] ResetEffW = clamp_w(SIZE_W'(RESET_WIDTH));
   localparam logic [SIZE_W-1:0] ResetEffH = clamp_h(SIZE_W'(RESET_HEIGHT));
   localparam logic [AREA_W-1:0] ResetArea = AREA_W'(ResetEffW) * AREA_W'(ResetEffH);
   localparam logic [AREA_W:0]   ResetV    = (AREA_W+1)'(ResetArea) + (AREA_W+1)'(ResetArea >> 2);

   logic [SIZE_W-1:0]  eff_w_ff, eff_w_in;
   logic [SIZE_W-1:0]  eff_h_ff, eff_h_in;
   logic [AREA_W-1:0]  area_ff, area_in;
   logic [PLANE_W-1:0] v_base_ff, v_base_in;
   logic [1:0]         settle_ff, settle_in;
   logic [AREA_W:0]    v_sum;

   // Register decode; unknown indexes are dropped
   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  eff_w_in = clamp_w(csr_wdata);
            CSR_FRAME_HEIGHT: eff_h_in = clamp_h(csr_wdata);
            default: ;
         endcase
      end
   end

   // Area, then V base = area * 5 / 4 = area + area / 4
   assign area_in   = AREA_W'(eff_w_ff) * AREA_W'(eff_h_ff);
   assign v_sum     = (AREA_W+1)'(area_ff) + (AREA_W+1)'(area_ff >> 2);
   assign v_base_in = v_sum[PLANE_W-1:0];

   // Busy holds while the area and V base registers follow a size write
   assign settle_in = csr_write ? 2'd2 : (settle_ff != 2'd0 ? settle_ff - 2'd1 : 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff  <= ResetEffW;
         eff_h_ff  <= ResetEffH;
         area_ff   <= ResetArea;
         v_base_ff <= ResetV[PLANE_W-1:0];
         settle_ff <= 2'd0;
      end else begin
         eff_w_ff  <= eff_w_in;
         eff_h_ff  <= eff_h_in;
         area_ff   <= area_in;
         v_base_ff <= v_base_in;
         settle_ff <= settle_in;
      end
   end

   assign geom.eff_width  = eff_w_ff;
   assign geom.eff_height = eff_h_ff;
   assign geom.u_base     = area_ff[PLANE_W-1:0];
   assign geom.v_base     = v_base_ff;
   assign geom.busy       = settle_ff != 2'd0;

   `ASSERT_CLK(a_write_busy, clock, reset, csr_write |=> geom.busy, "geometry not busy after write")
   `ASSERT_CLK(a_width_legal, clock, reset, !eff_w_ff[0] && eff_w_ff >= SIZE_W'(2), "bad width")
   `ASSERT_CLK(a_area_settled, clock, reset,
      !geom.busy |-> area_ff == AREA_W'(eff_w_ff) * AREA_W'(eff_h_ff), "area stale when idle")

endmodule

@@ sv/yuyv_to_planar_yuv420.sv @@
// Top level of the YUYV to planar YUV 4:2:0 converter.
// Depends on yuv420_pkg, yuv420_geom and assert_macros.svh.
//
// Usage:
//   req_*  : one YUYV group (Y0 U Y1 V) per request, raster order.
//   rsp_*  : one result per request: luma bytes with their Y plane offset,
//            and on odd rows U and V with their plane offsets.
//   csr_*  : size writes, index 0 frame width, index 1 frame height.
// Result: an accepted request shows its result in the output register
// in the following cycle. Throughput: one request per cycle while each result
// is taken and no size write is settling; the path is one 25-bit add and
// the row/frame end compares. A size write recomputes the plane bases
// through a multiplier and an adder stage, and requests are held off until they settle.
// Reset: 640x480, all counters and pointers zero, output register empty.
// Receiver stall: the output register holds its result; a new request is
// taken in the same cycle the held result is taken, otherwise it waits.
// rsp_frame_last marks the last group; counters then wrap to zero.
`include "assert_macros.svh"

module yuyv_to_planar_yuv420 #(
   parameter int MAX_WIDTH  = yuv420_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = yuv420_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [yuv420_pkg::BYTE_W-1:0]          req_luma_first,
   input  logic [yuv420_pkg::BYTE_W-1:0]          req_chroma_blue,
   input  logic [yuv420_pkg::BYTE_W-1:0]          req_luma_second,
   input  logic [yuv420_pkg::BYTE_W-1:0]          req_chroma_red,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [yuv420_pkg::LUMA_PTR_W-1:0]      rsp_luma_addr,
   output logic [yuv420_pkg::BYTE_W-1:0]          rsp_luma_a,
   output logic [yuv420_pkg::BYTE_W-1:0]          rsp_luma_b,
   output logic                                   rsp_chroma_valid,
   output logic [yuv420_pkg::PLANE_W-1:0]         rsp_u_addr,
   output logic [yuv420_pkg::PLANE_W-1:0]         rsp_v_addr,
   output logic [yuv420_pkg::BYTE_W-1:0]          rsp_u_out,
   output logic [yuv420_pkg::BYTE_W-1:0]          rsp_v_out,
   output logic                                   rsp_frame_last,
   // configuration channel
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [yuv420_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [yuv420_pkg::SIZE_W-1:0]          csr_wdata
);
   import yuv420_pkg::*;

   localparam int ColW  = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
   localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CmpW  = SIZE_W + 1;

   geom_type geom;

   logic                    req_accept;
   logic                    rsp_load;

   logic [ColW-1:0]         col_ff, col_in;
   logic [RowW-1:0]         row_ff, row_in;
   logic [LUMA_PTR_W-1:0]   luma_ptr_ff, luma_ptr_in;
   logic [CHROMA_PTR_W-1:0] chroma_ptr_ff, chroma_ptr_in;

   logic                    odd_row;
   logic                    row_end;
   logic                    frame_end;
   logic [CmpW-1:0]         col_next;
   logic [CmpW-1:0]         row_next;
   logic [CmpW-1:0]         groups;
   logic [PLANE_W-1:0]      u_addr_in, v_addr_in;

   logic                    rsp_valid_ff;
   logic [LUMA_PTR_W-1:0]   luma_addr_ff;
   logic [BYTE_W-1:0]       luma_a_ff, luma_b_ff, u_out_ff, v_out_ff;
   logic                    chroma_valid_ff, frame_last_ff;
   logic [PLANE_W-1:0]      u_addr_ff, v_addr_ff;

   // Size registers and plane bases
   yuv420_geom #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom)
   );

   assign csr_ready = 1'b1;

   // Handshake: output register frees when empty or being taken
   assign rsp_load   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = rsp_load && !geom.busy;
   assign req_accept = req_valid && req_ready;

   // Row and frame end detection
   assign groups    = CmpW'(geom.eff_width[SIZE_W-1:1]);
   assign col_next  = CmpW'(col_ff) + CmpW'(1);
   assign row_next  = CmpW'(row_ff) + CmpW'(1);
   assign odd_row   = row_ff[0];
   assign row_end   = col_next >= groups;
   assign frame_end = row_end && (row_next >= CmpW'(geom.eff_height));

   // Chroma plane offsets
   assign u_addr_in = odd_row ? geom.u_base + PLANE_W'(chroma_ptr_ff) : '0;
   assign v_addr_in = odd_row ? geom.v_base + PLANE_W'(chroma_ptr_ff) : '0;

   // Counter and pointer advance
   always_comb begin
      col_in        = col_ff;
      row_in        = row_ff;
      luma_ptr_in   = luma_ptr_ff;
      chroma_ptr_in = chroma_ptr_ff;
      if (req_accept) begin
         if (frame_end) begin
            col_in        = '0;
            row_in        = '0;
            luma_ptr_in   = '0;
            chroma_ptr_in = '0;
         end else begin
            luma_ptr_in = luma_ptr_ff + LUMA_PTR_W'(2);
            if (odd_row) begin
               chroma_ptr_in = chroma_ptr_ff + CHROMA_PTR_W'(1);
            end
            if (row_end) begin
               col_in = '0;
               row_in = row_next[RowW-1:0];
            end else begin
               col_in = col_next[ColW-1:0];
            end
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         luma_ptr_ff   <= '0;
         chroma_ptr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         luma_ptr_ff   <= luma_ptr_in;
         chroma_ptr_ff <= chroma_ptr_in;
         if (rsp_load) begin
            rsp_valid_ff <= req_accept;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         luma_addr_ff    <= luma_ptr_ff;
         luma_a_ff       <= req_luma_first;
         luma_b_ff       <= req_luma_second;
         chroma_valid_ff <= odd_row;
         u_addr_ff       <= u_addr_in;
         v_addr_ff       <= v_addr_in;
         u_out_ff        <= odd_row ? req_chroma_blue : '0;
         v_out_ff        <= odd_row ? req_chroma_red : '0;
         frame_last_ff   <= frame_end;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_luma_addr    = luma_addr_ff;
   assign rsp_luma_a       = luma_a_ff;
   assign rsp_luma_b       = luma_b_ff;
   assign rsp_chroma_valid = chroma_valid_ff;
   assign rsp_u_addr       = u_addr_ff;
   assign rsp_v_addr       = v_addr_ff;
   assign rsp_u_out        = u_out_ff;
   assign rsp_v_out        = v_out_ff;
   assign rsp_frame_last   = frame_last_ff;

   `ASSERT_CLK(a_busy_blocks, clock, reset, geom.busy |-> !req_ready, "request taken while busy")
   `ASSERT_CLK(a_frame_wrap, clock, reset,
      req_accept && frame_end |=> col_ff == '0 && row_ff == '0 && luma_ptr_ff == '0,
      "counters did not wrap at frame end")
   `ASSERT_CLK(a_chroma_zero, clock, reset,
      rsp_valid && !rsp_chroma_valid |-> rsp_u_addr == '0 && rsp_v_addr == '0
         && rsp_u_out == '0 && rsp_v_out == '0, "chroma fields not zero on even row")
   `ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result after reset")

endmodule

@@ verif/tb_yuyv_to_planar_yuv420.sv @@
// Testbench for yuyv_to_planar_yuv420: directed and random YUYV requests checked
// field by field against an in-bench address predictor, with random stalls on both sides.
// Depends on yuv420_pkg and the converter RTL.
module tb_yuyv_to_planar_yuv420;
   import yuv420_pkg::*;

   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 12;
   localparam int STALL_MAX     = 13;
   localparam int IDLE_LIMIT    = 1000;
   localparam int RANDOM_GROUPS = 1850;
   localparam int DRAIN_CYCLES  = 4;
   localparam int SMALL_FRAME   = 80;

   // Indexes the block has no register behind
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   // Byte patterns for the directed part: Y0, U, Y1, V
   localparam logic [31:0] EDGE_PATTERNS [8] = '{
      32'h00000000, 32'hFFFFFFFF, 32'hAA55AA55, 32'h55AA55AA,
      32'h00FFFF00, 32'hFF0000FF, 32'h01807FFE, 32'hFE7F8001
   };

   typedef logic [BYTE_W-1:0] pixel_type;

   typedef struct packed {
      logic [LUMA_PTR_W-1:0] luma_addr;
      pixel_type             luma_a;
      pixel_type             luma_b;
      logic                  chroma_valid;
      logic [PLANE_W-1:0]    u_addr;
      logic [PLANE_W-1:0]    v_addr;
      pixel_type             u_out;
      pixel_type             v_out;
      logic                  frame_last;
   } planar_write_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   pixel_type                req_luma_first;
   pixel_type                req_chroma_blue;
   pixel_type                req_luma_second;
   pixel_type                req_chroma_red;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [LUMA_PTR_W-1:0]    rsp_luma_addr;
   pixel_type                rsp_luma_a;
   pixel_type                rsp_luma_b;
   logic                     rsp_chroma_valid;
   logic [PLANE_W-1:0]       rsp_u_addr;
   logic [PLANE_W-1:0]       rsp_v_addr;
   pixel_type                rsp_u_out;
   pixel_type                rsp_v_out;
   logic                     rsp_frame_last;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [SIZE_W-1:0]        csr_wdata;

   yuyv_to_planar_yuv420 dut (.*);

   // Predictor state: size registers and frame counters
   logic [SIZE_W-1:0]        cfg_width;
   logic [SIZE_W-1:0]        cfg_height;
   logic [10:0]              col_q;
   logic [11:0]              row_q;
   logic [LUMA_PTR_W-1:0]    luma_ptr;
   logic [CHROMA_PTR_W-1:0]  chroma_ptr;
   logic [PLANE_W-1:0]       u_base;
   logic [PLANE_W-1:0]       v_base;

   planar_write_type         planar_writes_q [$];

   int                       mismatches;
   int                       groups_sent;
   int                       frames_done;
   int                       chroma_done;
   int                       writes_done;
   int                       idle_cycles;
   int                       req_calm;
   int                       rsp_calm;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Effective size: even width in [2, max], height in [1, max]
   function automatic int active_width();
      int w;
      w = int'(cfg_width) & ~1;
      if (w < 2) w = 2;
      if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH & ~1;
      return w;
   endfunction

   function automatic int active_height();
      int h;
      h = int'(cfg_height);
      if (h < 1) h = 1;
      if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
      return h;
   endfunction

   function automatic void refresh_bases();
      longint area;
      area = longint'(active_width()) * longint'(active_height());
      u_base = PLANE_W'(area);
      v_base = PLANE_W'((area * 5) / 4);
   endfunction

   // Plane writes for one YUYV group; advances the frame counters
   function automatic planar_write_type convert_group(pixel_type y0, pixel_type u,
                                                      pixel_type y1, pixel_type v);
      int               groups;
      int               rows;
      logic             odd_row;
      logic             row_end;
      logic             frame_end;
      planar_write_type w;
      groups    = active_width() / 2;
      rows      = active_height();
      odd_row   = row_q[0];
      row_end   = (int'(col_q) + 1) >= groups;
      frame_end = row_end && ((int'(row_q) + 1) >= rows);
      w = '0;
      w.luma_addr    = luma_ptr;
      w.luma_a       = y0;
      w.luma_b       = y1;
      w.chroma_valid = odd_row;
      if (odd_row) begin
         w.u_addr = u_base + PLANE_W'(chroma_ptr);
         w.v_addr = v_base + PLANE_W'(chroma_ptr);
         w.u_out  = u;
         w.v_out  = v;
      end
      w.frame_last = frame_end;
      if (frame_end) begin
         col_q      = '0;
         row_q      = '0;
         luma_ptr   = '0;
         chroma_ptr = '0;
      end else begin
         luma_ptr = luma_ptr + 2'd2;
         if (odd_row) chroma_ptr = chroma_ptr + 1'b1;
         if (row_end) begin
            col_q = '0;
            row_q = row_q + 1'b1;
         end else begin
            col_q = col_q + 1'b1;
         end
      end
      return w;
   endfunction

   // Per-request wait: mostly a random draw up to STALL_MAX, now and then a run with no gaps
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, STALL_MAX);
   endfunction

   // Mostly tiny sizes, some medium, a few past the clamp
   function automatic logic [SIZE_W-1:0] pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return SIZE_W'($urandom_range(0, 12));
      if (r < 9) return SIZE_W'($urandom_range(13, 600));
      return SIZE_W'($urandom_range(601, 8191));
   endfunction

   // One request; valid is left high so a back-to-back request needs no drop
   task automatic send_group(input pixel_type y0, input pixel_type u, input pixel_type y1,
                             input pixel_type v);
      int gap;
      gap = draw_wait(req_calm);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_luma_first  <= y0;
      req_chroma_blue <= u;
      req_luma_second <= y1;
      req_chroma_red  <= v;
      do @(posedge clock); while (!req_ready);
      planar_writes_q.push_back(convert_group(y0, u, y1, v));
      groups_sent++;
   endtask

   task automatic send_edge(input int k);
      logic [31:0] p;
      p = EDGE_PATTERNS[k % 8];
      send_group(p[31:24], p[23:16], p[15:8], p[7:0]);
   endtask

   task automatic send_random();
      send_group(pixel_type'($urandom), pixel_type'($urandom), pixel_type'($urandom),
                 pixel_type'($urandom));
   endtask

   // Size write, only once every outstanding result is back
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [SIZE_W-1:0] data);
      req_valid <= 1'b0;
      if (planar_writes_q.size() != 0) begin
         csr_valid <= 1'b0;
         while (planar_writes_q.size() != 0) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_FRAME_WIDTH: begin
            cfg_width = data;
            refresh_bases();
         end
         CSR_FRAME_HEIGHT: begin
            cfg_height = data;
            refresh_bases();
         end
         default: ;
      endcase
      writes_done++;
   endtask

   // Reset geometry, even row zero: luma only
   task automatic test_reset_size();
      for (int k = 0; k < 4; k++) send_edge(k);
   endtask

   // 4x2 frame entered mid-row: odd-row chroma, frame end, wrap
   task automatic test_small_frames();
      write_reg(CSR_FRAME_WIDTH, 13'd4);
      write_reg(CSR_FRAME_HEIGHT, 13'd2);
      for (int k = 0; k < 6; k++) send_edge(k + 2);
   endtask

   // Odd width, zero and oversized values
   task automatic test_size_clamps();
      write_reg(CSR_FRAME_WIDTH, 13'd1);
      write_reg(CSR_FRAME_HEIGHT, 13'd0);
      send_edge(1);
      send_edge(0);
      write_reg(CSR_FRAME_WIDTH, 13'h1FFF);
      write_reg(CSR_FRAME_HEIGHT, 13'h1FFF);
      send_edge(4);
      send_edge(5);
      write_reg(CSR_FRAME_WIDTH, 13'd3);
      write_reg(CSR_FRAME_HEIGHT, 13'd5);
      send_edge(6);
      send_edge(7);
   endtask

   // Writes to unused indexes must leave the size alone
   task automatic test_spare_index();
      write_reg(CSR_SPARE_LO, 13'd6);
      write_reg(CSR_SPARE_HI, 13'h1FFF);
      send_edge(2);
      send_edge(3);
   endtask

   // Shrink width and height while counters sit past the new ends
   task automatic test_resize_mid_frame();
      write_reg(CSR_FRAME_WIDTH, 13'd16);
      write_reg(CSR_FRAME_HEIGHT, 13'd6);
      for (int k = 0; k < 4; k++) send_edge(k);
      write_reg(CSR_FRAME_WIDTH, 13'd4);
      send_edge(4);
      send_edge(5);
      write_reg(CSR_FRAME_HEIGHT, 13'd1);
      send_edge(6);
      send_edge(7);
   endtask

   // Random sizes and content; small frames run whole, large ones partly
   task automatic test_random_frames();
      int sent;
      int span;
      int burst;
      sent = 0;
      while (sent < RANDOM_GROUPS) begin
         case ($urandom_range(0, 5))
            0: write_reg(CSR_FRAME_WIDTH, pick_size());
            1: write_reg(CSR_FRAME_HEIGHT, pick_size());
            2: begin
               write_reg($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                         SIZE_W'($urandom));
               write_reg(CSR_FRAME_HEIGHT, pick_size());
            end
            default: begin
               write_reg(CSR_FRAME_WIDTH, pick_size());
               write_reg(CSR_FRAME_HEIGHT, pick_size());
            end
         endcase
         span = (active_width() / 2) * active_height();
         if (span <= SMALL_FRAME)
            burst = span * $urandom_range(1, 2) + $urandom_range(0, 3);
         else
            burst = $urandom_range(20, 120);
         repeat (burst) send_random();
         sent += burst;
      end
   endtask

   // Receiver: draws a stall before each result
   initial begin : rsp_side
      int stall;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(rsp_calm);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted result with the oldest expected plane write
   always @(posedge clock) begin : check_results
      planar_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (planar_writes_q.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
         end else begin
            want = planar_writes_q.pop_front();
            check_field("luma_addr", want.luma_addr, rsp_luma_addr);
            check_field("luma_a", want.luma_a, rsp_luma_a);
            check_field("luma_b", want.luma_b, rsp_luma_b);
            check_field("chroma_valid", want.chroma_valid, rsp_chroma_valid);
            check_field("u_addr", want.u_addr, rsp_u_addr);
            check_field("v_addr", want.v_addr, rsp_v_addr);
            check_field("u_out", want.u_out, rsp_u_out);
            check_field("v_out", want.v_out, rsp_v_out);
            check_field("frame_last", want.frame_last, rsp_frame_last);
            if (want.frame_last) frames_done++;
            if (want.chroma_valid) chroma_done++;
         end
      end
   end

   // Watchdog: too long with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_luma_first  <= '0;
      req_chroma_blue <= '0;
      req_luma_second <= '0;
      req_chroma_red  <= '0;
      csr_valid       <= 1'b0;
      csr_index       <= CSR_FRAME_WIDTH;
      csr_wdata       <= '0;
      mismatches  = 0;
      groups_sent = 0;
      frames_done = 0;
      chroma_done = 0;
      writes_done = 0;
      req_calm    = 0;
      rsp_calm    = 0;
      cfg_width   = SIZE_W'(RESET_WIDTH);
      cfg_height  = SIZE_W'(RESET_HEIGHT);
      col_q       = '0;
      row_q       = '0;
      luma_ptr    = '0;
      chroma_ptr  = '0;
      refresh_bases();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_size();
      test_small_frames();
      test_size_clamps();
      test_spare_index();
      test_resize_mid_frame();
      test_random_frames();

      // Drain outstanding results, then allow the output stage to settle
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (planar_writes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d YUYV requests: %0d frame ends, %0d chroma writes, %0d size writes.",
               groups_sent, frames_done, chroma_done, writes_done);
      $display("Field mismatches seen: %0d.", mismatches);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
